@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each macro expands to one labeled concurrent assertion on a rising clock
// edge, disabled while the synchronous reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/mpfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfc_pkg
// Types and constants for the Modbus position frame checker.
// ----------------------------------------------------------------------------
package mpfc_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  FUNC_READ   = 8'h03;
  localparam logic [7:0]  COUNT_FIELD = 8'h04;

  // Byte positions inside a frame
  localparam logic [3:0] POS_ADDR     = 4'd0;
  localparam logic [3:0] POS_FUNC     = 4'd1;
  localparam logic [3:0] POS_COUNT    = 4'd2;
  localparam logic [3:0] POS_ANGLE_HI = 4'd5;
  localparam logic [3:0] POS_ANGLE_LO = 4'd6;
  localparam logic [3:0] POS_CRC_LO   = 4'd7;
  localparam logic [3:0] POS_CRC_HI   = 4'd8;
  localparam logic [3:0] CRC_SPAN     = 4'd7;
  localparam logic [3:0] COUNT_MAX    = 4'd15;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_BAD_HDR = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] angle;
  } frame_result_t;

endpackage

@@ hdl/mpfc_crc_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfc_crc_step
// Modbus CRC-16 update by one byte, LSB first, reflected polynomial.
// ----------------------------------------------------------------------------
module mpfc_crc_step (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);
  import mpfc_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

@@ hdl/mpfc_frame.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfc_frame
// Per-frame state: byte count, running CRC, header check, angle capture,
// and the status decision on the last byte of a frame.
// ----------------------------------------------------------------------------
module mpfc_frame (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_frame,
  input  logic [7:0]              device_address,
  output mpfc_pkg::frame_result_t result
);
  import mpfc_pkg::*;

  logic [3:0]  byte_count;
  logic [15:0] crc_running;
  logic [7:0]  crc_low_seen;
  logic        header_ok;
  logic [7:0]  angle_high_byte;
  logic [7:0]  angle_low_byte;
  logic [15:0] held_angle;

  logic [15:0] crc_step_out;
  logic        header_ok_next;
  logic        crc_match;
  status_t     status_next;

  mpfc_crc_step u_crc (
    .crc_in  (crc_running),
    .data    (data_byte),
    .crc_out (crc_step_out)
  );

  always_comb begin
    header_ok_next = header_ok;
    case (byte_count)
      POS_ADDR:  header_ok_next = (data_byte == device_address);
      POS_FUNC:  header_ok_next = header_ok && (data_byte == FUNC_READ);
      POS_COUNT: header_ok_next = header_ok && (data_byte == COUNT_FIELD);
      default:   header_ok_next = header_ok;
    endcase
  end

  // crc_running holds the CRC of the first seven bytes from position 7 on
  assign crc_match = (crc_low_seen == crc_running[7:0]) &&
                     (data_byte == crc_running[15:8]);

  always_comb begin
    if (byte_count != POS_CRC_HI) begin
      status_next = ST_BAD_LEN;
    end else if (!crc_match) begin
      status_next = ST_BAD_CRC;
    end else if (!header_ok) begin
      status_next = ST_BAD_HDR;
    end else begin
      status_next = ST_OK;
    end
  end

  always_comb begin
    result.status = status_next;
    result.angle  = (status_next == ST_OK) ? {angle_high_byte, angle_low_byte}
                                           : held_angle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      crc_running     <= CRC_INIT;
      crc_low_seen    <= '0;
      header_ok       <= 1'b0;
      angle_high_byte <= '0;
      angle_low_byte  <= '0;
      held_angle      <= '0;
    end else if (step) begin
      if (end_of_frame) begin
        byte_count      <= '0;
        crc_running     <= CRC_INIT;
        crc_low_seen    <= '0;
        header_ok       <= 1'b0;
        angle_high_byte <= '0;
        angle_low_byte  <= '0;
        held_angle      <= result.angle;
      end else begin
        if (byte_count < CRC_SPAN) begin
          crc_running <= crc_step_out;
        end
        header_ok <= header_ok_next;
        if (byte_count == POS_ANGLE_HI) begin
          angle_high_byte <= data_byte;
        end
        if (byte_count == POS_ANGLE_LO) begin
          angle_low_byte <= data_byte;
        end
        if (byte_count == POS_CRC_LO) begin
          crc_low_seen <= data_byte;
        end
        if (byte_count != COUNT_MAX) begin
          byte_count <= byte_count + 4'd1;
        end
      end
    end
  end

endmodule

@@ hdl/modbus_position_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_position_frame_checker
// Checks Modbus RTU read-response frames carrying an encoder angle.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one received byte per transfer, with
//   end_of_frame high on the last byte of a frame.
// Output channel (out_valid/out_ready): one transfer per frame, on its last
//   byte: status (ok, bad length, bad CRC, wrong header) and the held angle,
//   which an ok frame updates first.
// cfg_we/cfg_wdata write device_address (reset value 1); write only while
//   no byte and no frame result is in flight.
// Throughput: one byte per cycle while no last byte waits on the output.
//   A byte goes into an input register, then the frame logic (one CRC byte
//   update) runs between that register and the output register, which
//   raises out_valid when it takes the result of a last byte.
// Stall: while a result waits on out_ready, bytes that end no frame keep
//   flowing; a further last byte waits in the input register and in_ready
//   drops until the pending result is taken.
// Reset clears the frame state, the held angle and the valid flags of both registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modbus_position_frame_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_frame,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [15:0]            angle
);
  import mpfc_pkg::*;

  logic          [7:0] device_address;
  logic                in_full;
  logic          [7:0] in_byte;
  logic                in_eof;
  logic                stage_go;
  frame_result_t       result;
  frame_result_t       out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd1;
    end else if (cfg_we) begin
      device_address <= cfg_wdata;
    end
  end

  // A held byte moves on unless it ends a frame and the output is occupied
  assign stage_go = in_full && (!in_eof || !out_valid || out_ready);
  assign in_ready = !in_full || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
      in_eof  <= end_of_frame;
    end
  end

  mpfc_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .step           (stage_go),
    .data_byte      (in_byte),
    .end_of_frame   (in_eof),
    .device_address (device_address),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_go && in_eof) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && in_eof) begin
      out_result <= result;
    end
  end

  assign status = out_result.status;
  assign angle  = out_result.angle;

  `ASSERT_IMPL(a_eof_blocks_on_stall, clk, rst,
               in_full && in_eof && out_valid && !out_ready, !in_ready)
  `ASSERT_NEXT(a_eof_gives_result, clk, rst, stage_go && in_eof, out_valid)
  `ASSERT_NEXT(a_taken_result_clears, clk, rst,
               out_valid && out_ready && !(stage_go && in_eof), !out_valid)
  `ASSERT_IMPL(a_result_has_source, clk, rst, $rose(out_valid),
               $past(stage_go && in_eof))

endmodule
